>>> hw/rtl/quadrature_position_velocity_core_macros.svh
`ifndef QUADRATURE_POSITION_VELOCITY_CORE_MACROS_SVH
`define QUADRATURE_POSITION_VELOCITY_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define QPV_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qpv check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define QPV_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qpv check failed");

`endif

>>> hw/rtl/qpv_pkg.sv
package qpv_pkg;

	localparam int SCALE_W = 20;
	localparam int PROD_W  = 32 + SCALE_W;
	localparam int CNT_W   = $clog2(PROD_W);

	localparam logic [SCALE_W-1:0] TICK_SCALE = 20'd1000000;
	localparam logic [31:0]        POS_MAX    = 32'h7fff_ffff;
	localparam logic [31:0]        NEG_MIN    = 32'h8000_0000;
	localparam logic [1:0]         CODE_RESET = 2'b01;

	typedef enum logic {
		OP_PIN,
		OP_VEL
	} qpv_op_t;

	typedef struct packed {
		logic        func;
		logic        pin_a;
		logic        pin_b;
		logic [31:0] time_us;
	} qpv_in_t;

	typedef struct packed {
		logic signed [31:0] position;
		logic signed [31:0] velocity;
		logic               zero_interval;
	} qpv_out_t;

	typedef struct packed {
		qpv_op_t     op;
		logic [1:0]  code;
		logic [31:0] time_us;
	} qpv_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qpv_qstat_t;

endpackage

>>> hw/rtl/qpv_front.sv
module qpv_front import qpv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  qpv_in_t    in_item,
	input  qpv_qstat_t qstat,
	output logic       push,
	output qpv_cmd_t   push_cmd
);

	logic     vld_s1;
	qpv_cmd_t cmd_s1;
	qpv_cmd_t cmd_new;
	logic     accept;

	always_comb begin
		cmd_new.code    = {in_item.pin_b, in_item.pin_a};
		cmd_new.time_us = in_item.time_us;
		if (in_item.func) begin
			cmd_new.op = OP_VEL;
		end else begin
			cmd_new.op = OP_PIN;
		end
	end

	assign push     = vld_s1 && !qstat.full;
	assign push_cmd = cmd_s1;
	assign in_stall = vld_s1 && qstat.full;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_new;
		end
	end

endmodule

>>> hw/rtl/qpv_fifo.sv
module qpv_fifo import qpv_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  qpv_cmd_t   push_cmd,
	input  logic       pop,
	output qpv_cmd_t   pop_cmd,
	output qpv_qstat_t qstat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	qpv_cmd_t        mem_q [DEPTH];
	logic [AW-1:0]   wptr_q;
	logic [AW-1:0]   rptr_q;
	logic [CW-1:0]   count_q;

	assign qstat.full  = (count_q == CW'(DEPTH));
	assign qstat.empty = (count_q == '0);
	assign pop_cmd     = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> hw/rtl/qpv_back.sv
module qpv_back import qpv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr,
	input  logic       cfg_data,
	input  qpv_qstat_t qstat,
	input  qpv_cmd_t   pop_cmd,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output qpv_out_t   out_item
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t            state_q;
	logic              invert_q;
	logic [1:0]        last_code_q;
	logic [31:0]       tick_q;
	logic [31:0]       prev_time_q;
	logic [31:0]       prev_count_q;
	logic [31:0]       speed_q;
	logic [31:0]       dt_q;
	logic [31:0]       mag_q;
	logic              neg_q;
	logic              zero_q;
	logic [PROD_W-1:0] dvd_q;
	logic [31:0]       rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q;
	qpv_out_t          out_item_q;

	logic              out_free;
	logic              emit;
	logic [1:0]        delta;
	logic [1:0]        code_keep;
	logic [31:0]       tick_nxt;
	logic [31:0]       pos_pin;
	logic [31:0]       pos_cur;
	logic [31:0]       dt;
	logic [31:0]       diff;
	logic [31:0]       mag;
	logic [32:0]       trial;
	logic              qbit;
	logic [31:0]       vel;

	assign out_free = !out_valid_q || !out_stall;
	assign pop      = (state_q == ST_IDLE) && !qstat.empty && out_free;
	assign emit     = (pop && (pop_cmd.op == OP_PIN)) || ((state_q == ST_EMIT) && out_free);

	always_comb begin
		delta     = last_code_q ^ pop_cmd.code;
		tick_nxt  = tick_q + 32'(delta[0]) - 32'(delta[1]);
		code_keep = (pop_cmd.code == 2'b01 || pop_cmd.code == 2'b10) ?
			~pop_cmd.code : pop_cmd.code;
		pos_pin   = invert_q ? (32'd0 - tick_nxt) : tick_nxt;
		pos_cur   = invert_q ? (32'd0 - tick_q) : tick_q;
		dt        = pop_cmd.time_us - prev_time_q;
		diff      = pos_cur - prev_count_q;
		mag       = diff[31] ? (32'd0 - diff) : diff;
	end

	// one restoring step
	always_comb begin
		trial = {rem_q, dvd_q[PROD_W-1]};
		qbit  = (trial >= {1'b0, dt_q});
	end

	// sign, saturation and zero-interval result of the magnitude quotient
	always_comb begin
		if (zero_q) begin
			vel = '0;
		end else if (neg_q) begin
			if ((|dvd_q[PROD_W-1:32]) || (dvd_q[31] && (|dvd_q[30:0]))) begin
				vel = NEG_MIN;
			end else begin
				vel = 32'd0 - dvd_q[31:0];
			end
		end else if (|dvd_q[PROD_W-1:31]) begin
			vel = POS_MAX;
		end else begin
			vel = dvd_q[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			invert_q     <= 1'b0;
			last_code_q  <= CODE_RESET;
			tick_q       <= '0;
			prev_time_q  <= '0;
			prev_count_q <= '0;
			speed_q      <= '0;
			dt_q         <= '0;
			mag_q        <= '0;
			neg_q        <= 1'b0;
			zero_q       <= 1'b0;
			dvd_q        <= '0;
			rem_q        <= '0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
			out_item_q   <= '0;
		end else begin
			if (cfg_wr) begin
				invert_q <= cfg_data;
			end
			out_valid_q <= emit || (out_valid_q && out_stall);
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (pop_cmd.op == OP_PIN) begin
							tick_q                   <= tick_nxt;
							last_code_q              <= code_keep;
							out_item_q.position      <= pos_pin;
							out_item_q.velocity      <= speed_q;
							out_item_q.zero_interval <= 1'b0;
						end else begin
							prev_time_q  <= pop_cmd.time_us;
							prev_count_q <= pos_cur;
							dt_q         <= dt;
							mag_q        <= mag;
							neg_q        <= diff[31];
							zero_q       <= (dt == '0);
							state_q      <= (dt == '0) ? ST_EMIT : ST_MUL;
						end
					end
				end
				ST_MUL: begin
					dvd_q   <= PROD_W'(mag_q) * PROD_W'(TICK_SCALE);
					rem_q   <= '0;
					cnt_q   <= CNT_W'(PROD_W - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= qbit ? 32'(trial - {1'b0, dt_q}) : trial[31:0];
					dvd_q <= {dvd_q[PROD_W-2:0], qbit};
					if (cnt_q == '0) begin
						state_q <= ST_EMIT;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						speed_q                  <= vel;
						out_item_q.position      <= pos_cur;
						out_item_q.velocity      <= vel;
						out_item_q.zero_interval <= zero_q;
						state_q                  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

>>> hw/rtl/quadrature_position_velocity_core.sv
// pin sample: front register, queue, output register; velocity: MUL, DIV, EMIT
// states, straight to EMIT when no time has elapsed; throughput: one pin sample
// per cycle unless the queue is full or the output stalls; a velocity update holds
// the back end in the one-bit-per-cycle restoring divider over a 52-bit product
// reset: arst_n clears position, speed, timestamps and inversion, stored code to A set
module quadrature_position_velocity_core import qpv_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  qpv_in_t  in_item,
	output logic     out_valid,
	input  logic     out_stall,
	output qpv_out_t out_item,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  logic     cfg_data
);

	qpv_qstat_t qstat;
	qpv_cmd_t   push_cmd;
	qpv_cmd_t   pop_cmd;
	logic       push;
	logic       pop;

	assign cfg_ready = 1'b1;

	qpv_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.qstat    (qstat),
		.push     (push),
		.push_cmd (push_cmd)
	);

	qpv_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.qstat    (qstat)
	);

	qpv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.qstat     (qstat),
		.pop_cmd   (pop_cmd),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

>>> hw/rtl/qpv_checker.sv
`include "quadrature_position_velocity_core_macros.svh"

module qpv_checker import qpv_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     cfg_valid,
	input logic     cfg_ready,
	input logic     out_valid,
	input logic     out_stall,
	input qpv_out_t out_item
);

	`QPV_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`QPV_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_item))
	`QPV_ASSERT_NOW(a_zero_speed, out_valid && out_item.zero_interval, out_item.velocity == 0)
	`QPV_ASSERT_NOW(a_cfg_open, cfg_valid, cfg_ready)

endmodule

bind quadrature_position_velocity_core qpv_checker u_qpv_checker (.*);
